### rtl/tfmw_pkg.sv
// ----------------------------------------------------------------------------
// tfmw_pkg
// Shared types and constants for the flight mode watchdog: configuration
// register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package tfmw_pkg;

  // configuration port geometry
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_STEP_SIZE     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SPEED_LIMIT   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HOVER_TICKS   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TAKEOFF_TICKS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LAND_TICKS    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RESET_TICKS   = 3'd5;

  // reset values
  localparam logic [13:0] RST_STEP_SIZE     = 14'd2458;
  localparam logic [13:0] RST_SPEED_LIMIT   = 14'd12288;
  localparam logic [14:0] RST_HOVER_TICKS   = 15'd150;
  localparam logic [15:0] RST_TAKEOFF_TICKS = 16'd200;
  localparam logic [15:0] RST_LAND_TICKS    = 16'd200;
  localparam logic [15:0] RST_RESET_TICKS   = 16'd100;

  // configuration bundle handed from the register file to the controller
  typedef struct packed {
    logic [13:0] step_size;
    logic [13:0] speed_limit;
    logic [14:0] hover_ticks;
    logic [15:0] takeoff_ticks;
    logic [15:0] land_ticks;
    logic [15:0] reset_ticks;
  } cfg_t;

endpackage

### rtl/teleop_flight_mode_watchdog_unit.sv
// ----------------------------------------------------------------------------
// teleop_flight_mode_watchdog_unit
// Teleoperation flight mode controller with velocity stepping and an idle
// watchdog, behind stream-style input, result and configuration ports.
// ----------------------------------------------------------------------------
// Every input request (a keypress or a time tick) yields exactly one result
// holding the mode, the three velocity commands and the command code after
// that request. One request is taken per clock cycle unless a held-off
// result stalls the input side. A request first sits in the input
// register; once the result register can take it, the whole mode, phase
// timer and watchdog update is written at once into the state and result
// registers. A held-off result stalls the input side only once both the
// input and result registers are full. Configuration writes are taken every
// cycle and must be made while the block is idle.
// ----------------------------------------------------------------------------
module teleop_flight_mode_watchdog_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input request stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] key_code
  input  logic                          in_tuser,   // [0] action (1 tick, 0 key)
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [2:0] mode, [17:3] vel_x, [32:18] vel_y, [46:33] vel_z,
  // [49:47] command, [55:50] zero
  output logic [55:0]                   out_tdata,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tfmw_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tfmw_pkg::CfgDataW-1:0] cfg_data
);
  import tfmw_pkg::*;

  cfg_t               cfg;
  logic               in_valid_r, in_valid_nxt;
  logic               in_action_r;
  logic [7:0]         in_key_r;
  logic               take;
  logic               res_valid;
  logic [2:0]         res_mode;
  logic signed [14:0] res_vel_x;
  logic signed [14:0] res_vel_y;
  logic [13:0]        res_vel_z;
  logic [2:0]         res_command;

  // configuration registers
  assign cfg_ready = 1'b1;

  tfmw_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // input register, advanced when the result register can take a new request
  assign take      = in_valid_r && (!res_valid || out_tready);
  assign in_tready = !in_valid_r || take;

  always_comb begin
    if (in_tvalid && in_tready) in_valid_nxt = 1'b1;
    else if (take)              in_valid_nxt = 1'b0;
    else                        in_valid_nxt = in_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_action_r <= in_tuser;
      in_key_r    <= in_tdata;
    end
  end

  // mode controller with result register
  tfmw_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_take   (take),
    .item_action (in_action_r),
    .item_key    (in_key_r),
    .cfg         (cfg),
    .res_ready   (out_tready),
    .res_valid   (res_valid),
    .res_mode    (res_mode),
    .res_vel_x   (res_vel_x),
    .res_vel_y   (res_vel_y),
    .res_vel_z   (res_vel_z),
    .res_command (res_command)
  );

  // result packing
  assign out_tvalid = res_valid;
  assign out_tdata  = {6'b000000, res_command, res_vel_z, res_vel_y, res_vel_x, res_mode};

endmodule

### rtl/tfmw_cfg_regs.sv
// ----------------------------------------------------------------------------
// tfmw_cfg_regs
// Configuration register file; a write request is taken every cycle and
// indexes outside the register list are dropped.
// ----------------------------------------------------------------------------
module tfmw_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [tfmw_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [tfmw_pkg::CfgDataW-1:0] wr_data,
  output tfmw_pkg::cfg_t                cfg
);
  import tfmw_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode, data truncated to each register's width
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_STEP_SIZE:     cfg_nxt.step_size     = wr_data[13:0];
        REG_SPEED_LIMIT:   cfg_nxt.speed_limit   = wr_data[13:0];
        REG_HOVER_TICKS:   cfg_nxt.hover_ticks   = wr_data[14:0];
        REG_TAKEOFF_TICKS: cfg_nxt.takeoff_ticks = wr_data[15:0];
        REG_LAND_TICKS:    cfg_nxt.land_ticks    = wr_data[15:0];
        REG_RESET_TICKS:   cfg_nxt.reset_ticks   = wr_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_size     <= RST_STEP_SIZE;
      cfg_r.speed_limit   <= RST_SPEED_LIMIT;
      cfg_r.hover_ticks   <= RST_HOVER_TICKS;
      cfg_r.takeoff_ticks <= RST_TAKEOFF_TICKS;
      cfg_r.land_ticks    <= RST_LAND_TICKS;
      cfg_r.reset_ticks   <= RST_RESET_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/tfmw_ctrl.sv
// ----------------------------------------------------------------------------
// tfmw_ctrl
// Flight mode state machine, velocity stepping with clamps, phase timers and
// idle watchdog; also owns the result register.
// ----------------------------------------------------------------------------
module tfmw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_take,
  input  logic                 item_action,
  input  logic [7:0]           item_key,
  input  tfmw_pkg::cfg_t       cfg,
  input  logic                 res_ready,
  output logic                 res_valid,
  output logic [2:0]           res_mode,
  output logic signed [14:0]   res_vel_x,
  output logic signed [14:0]   res_vel_y,
  output logic [13:0]          res_vel_z,
  output logic [2:0]           res_command
);
  import tfmw_pkg::*;

  typedef enum logic [2:0] {
    MODE_LANDED    = 3'd0,
    MODE_TAKEOFF   = 3'd1,
    MODE_HOVER     = 3'd2,
    MODE_FLY       = 3'd3,
    MODE_LANDING   = 3'd4,
    MODE_RESETTING = 3'd5,
    MODE_HALTED    = 3'd6
  } mode_t;

  localparam logic       ACT_KEY  = 1'b0;

  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_VEL     = 3'd1;
  localparam logic [2:0] CMD_TAKEOFF = 3'd2;
  localparam logic [2:0] CMD_LAND    = 3'd3;
  localparam logic [2:0] CMD_RESET   = 3'd4;

  localparam logic [1:0] AFTER_NONE  = 2'd0;
  localparam logic [1:0] AFTER_RESET = 2'd1;
  localparam logic [1:0] AFTER_HALT  = 2'd2;

  localparam logic [7:0] KEY_T = 8'h54;
  localparam logic [7:0] KEY_L = 8'h4C;
  localparam logic [7:0] KEY_R = 8'h52;
  localparam logic [7:0] KEY_Q = 8'h51;
  localparam logic [7:0] KEY_X = 8'h78;
  localparam logic [7:0] KEY_H = 8'h68;
  localparam logic [7:0] KEY_LL = 8'h6C;
  localparam logic [7:0] KEY_K = 8'h6B;
  localparam logic [7:0] KEY_J = 8'h6A;
  localparam logic [7:0] KEY_A = 8'h61;
  localparam logic [7:0] KEY_Z = 8'h7A;

  // symmetric clamp of a widened velocity
  function automatic logic signed [14:0] clamp_sym(input logic signed [16:0] v,
                                                   input logic [13:0] lim);
    logic signed [16:0] lim_s;
    logic signed [16:0] r;
    lim_s = signed'({3'b000, lim});
    if (v >= lim_s)       r = lim_s;
    else if (v <= -lim_s) r = -lim_s;
    else                  r = v;
    return r[14:0];
  endfunction

  // floor-at-zero clamp of the vertical velocity
  function automatic logic [13:0] clamp_up(input logic signed [16:0] v,
                                           input logic [13:0] lim);
    logic signed [16:0] lim_s;
    logic [13:0]        r;
    lim_s = signed'({3'b000, lim});
    if (v >= lim_s)        r = lim;
    else if (v <= 17'sd0)  r = '0;
    else                   r = v[13:0];
    return r;
  endfunction

  mode_t              mode_r,   mode_nxt;
  logic [15:0]        phase_r,  phase_nxt;
  logic [15:0]        idle_r,   idle_nxt;
  logic signed [14:0] vx_r,     vx_nxt;
  logic signed [14:0] vy_r,     vy_nxt;
  logic [13:0]        vz_r,     vz_nxt;
  logic               hfired_r, hfired_nxt;
  logic               lfired_r, lfired_nxt;
  logic [1:0]         after_r,  after_nxt;
  logic               valid_r,  valid_nxt;
  logic [2:0]         cmd_r,    cmd_nxt;

  logic signed [16:0] step_s;
  logic signed [16:0] vx_w, vy_w, vz_w;
  logic signed [16:0] vx_pre, vy_pre, vz_pre;
  logic               vel_upd;
  logic [15:0]        phase_inc;
  logic [15:0]        phase_len;
  logic               phase_end;
  logic [15:0]        idle_inc;

  // shared operands
  assign step_s   = signed'({3'b000, cfg.step_size});
  assign vx_w     = 17'(vx_r);
  assign vy_w     = 17'(vy_r);
  assign vz_w     = signed'({3'b000, vz_r});
  assign phase_inc = phase_r + 16'd1;
  assign idle_inc  = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;

  // length of the running timed phase
  always_comb begin
    unique case (mode_r)
      MODE_TAKEOFF: phase_len = cfg.takeoff_ticks;
      MODE_LANDING: phase_len = cfg.land_ticks;
      default:      phase_len = cfg.reset_ticks;
    endcase
  end

  assign phase_end = (phase_inc >= phase_len) || (phase_inc == 16'd0);

  // next state for one request
  always_comb begin
    mode_nxt   = mode_r;
    phase_nxt  = phase_r;
    idle_nxt   = idle_r;
    vx_nxt     = vx_r;
    vy_nxt     = vy_r;
    vz_nxt     = vz_r;
    hfired_nxt = hfired_r;
    lfired_nxt = lfired_r;
    after_nxt  = after_r;
    cmd_nxt    = CMD_NONE;
    vx_pre     = vx_w;
    vy_pre     = vy_w;
    vz_pre     = vz_w;
    vel_upd    = 1'b0;

    if (item_action == ACT_KEY) begin
      unique case (mode_r) inside
        MODE_LANDED: begin
          if (item_key == KEY_T) begin
            mode_nxt  = MODE_TAKEOFF;
            phase_nxt = '0;
            vx_nxt = '0; vy_nxt = '0; vz_nxt = '0;
          end else if (item_key == KEY_R) begin
            mode_nxt  = MODE_RESETTING;
            phase_nxt = '0;
            vx_nxt = '0; vy_nxt = '0; vz_nxt = '0;
          end else if (item_key == KEY_Q) begin
            mode_nxt = MODE_HALTED;
            vx_nxt = '0; vy_nxt = '0; vz_nxt = '0;
          end
        end
        MODE_HOVER, MODE_FLY: begin
          case (item_key) inside
            KEY_R, KEY_Q, KEY_L: begin
              mode_nxt  = MODE_LANDING;
              phase_nxt = '0;
              vx_nxt = '0; vy_nxt = '0; vz_nxt = '0;
              if (item_key == KEY_R)      after_nxt = AFTER_RESET;
              else if (item_key == KEY_Q) after_nxt = AFTER_HALT;
              else                        after_nxt = AFTER_NONE;
            end
            KEY_X: begin
              vel_upd = 1'b1;
              vx_pre = '0; vy_pre = '0; vz_pre = '0;
              mode_nxt = MODE_HOVER;
            end
            KEY_H:  begin vel_upd = 1'b1; vy_pre = vy_w + step_s; mode_nxt = MODE_FLY; end
            KEY_LL: begin vel_upd = 1'b1; vy_pre = vy_w - step_s; mode_nxt = MODE_FLY; end
            KEY_K:  begin vel_upd = 1'b1; vx_pre = vx_w + step_s; mode_nxt = MODE_FLY; end
            KEY_J:  begin vel_upd = 1'b1; vx_pre = vx_w - step_s; mode_nxt = MODE_FLY; end
            KEY_A:  begin vel_upd = 1'b1; vz_pre = vz_w + step_s; mode_nxt = MODE_FLY; end
            KEY_Z:  begin vel_upd = 1'b1; vz_pre = vz_w - step_s; mode_nxt = MODE_FLY; end
            default: ;
          endcase
          // clamp all axes and clear the watchdog after a steer key
          if (vel_upd) begin
            vx_nxt     = clamp_sym(vx_pre, cfg.speed_limit);
            vy_nxt     = clamp_sym(vy_pre, cfg.speed_limit);
            vz_nxt     = clamp_up(vz_pre, cfg.speed_limit);
            idle_nxt   = '0;
            hfired_nxt = 1'b0;
            lfired_nxt = 1'b0;
            cmd_nxt    = CMD_VEL;
          end
        end
        default: ;
      endcase
    end else begin
      unique case (mode_r) inside
        MODE_TAKEOFF: begin
          cmd_nxt   = CMD_TAKEOFF;
          phase_nxt = phase_inc;
          if (phase_end) begin
            mode_nxt   = MODE_HOVER;
            phase_nxt  = '0;
            idle_nxt   = '0;
            hfired_nxt = 1'b0;
            lfired_nxt = 1'b0;
          end
        end
        MODE_LANDING: begin
          cmd_nxt   = CMD_LAND;
          phase_nxt = phase_inc;
          if (phase_end) begin
            phase_nxt = '0;
            after_nxt = AFTER_NONE;
            if (after_r == AFTER_RESET)     mode_nxt = MODE_RESETTING;
            else if (after_r == AFTER_HALT) mode_nxt = MODE_HALTED;
            else                            mode_nxt = MODE_LANDED;
          end
        end
        MODE_RESETTING: begin
          cmd_nxt   = CMD_RESET;
          phase_nxt = phase_inc;
          if (phase_end) begin
            phase_nxt = '0;
            mode_nxt  = MODE_LANDED;
          end
        end
        MODE_HOVER, MODE_FLY: begin
          // idle watchdog: forced hover, then forced landing
          idle_nxt = idle_inc;
          if (!hfired_r && (idle_inc > {1'b0, cfg.hover_ticks})) begin
            hfired_nxt = 1'b1;
            vx_nxt = '0; vy_nxt = '0; vz_nxt = '0;
            mode_nxt = MODE_HOVER;
            cmd_nxt  = CMD_VEL;
          end
          if (!lfired_r && (idle_inc > {cfg.hover_ticks, 1'b0})) begin
            lfired_nxt = 1'b1;
            vx_nxt = '0; vy_nxt = '0; vz_nxt = '0;
            phase_nxt = '0;
            mode_nxt  = MODE_LANDING;
            after_nxt = AFTER_NONE;
            cmd_nxt   = CMD_LAND;
          end
        end
        default: ;
      endcase
    end
  end

  // result register occupancy
  always_comb begin
    if (item_take)      valid_nxt = 1'b1;
    else if (res_ready) valid_nxt = 1'b0;
    else                valid_nxt = valid_r;
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_LANDED;
      phase_r  <= '0;
      idle_r   <= '0;
      vx_r     <= '0;
      vy_r     <= '0;
      vz_r     <= '0;
      hfired_r <= 1'b0;
      lfired_r <= 1'b0;
      after_r  <= AFTER_NONE;
      valid_r  <= 1'b0;
      cmd_r    <= CMD_NONE;
    end else begin
      valid_r <= valid_nxt;
      if (item_take) begin
        mode_r   <= mode_nxt;
        phase_r  <= phase_nxt;
        idle_r   <= idle_nxt;
        vx_r     <= vx_nxt;
        vy_r     <= vy_nxt;
        vz_r     <= vz_nxt;
        hfired_r <= hfired_nxt;
        lfired_r <= lfired_nxt;
        after_r  <= after_nxt;
        cmd_r    <= cmd_nxt;
      end
    end
  end

  // state only moves with a new result, so it doubles as the result payload
  assign res_valid   = valid_r;
  assign res_mode    = mode_r;
  assign res_vel_x   = vx_r;
  assign res_vel_y   = vy_r;
  assign res_vel_z   = vz_r;
  assign res_command = cmd_r;

endmodule
